// ===== rtl/dlr_pkg.sv =====
// dlr_pkg: shared widths, codes, command and divider structs for the styled line rasterizer
// no dependencies; used by every rtl file of the block
`default_nettype none

package dlr_pkg;

   // coordinate and fixed-point widths
   localparam int COORD_BITS = 10;
   localparam int FRAC_BITS  = 16;
   localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 1;
   localparam int INC_BITS   = FRAC_BITS + 2;
   localparam int QUOT_BITS  = FRAC_BITS + 1;
   localparam int STEP_BITS  = COORD_BITS + 1;

   // divider sizing: dividend is 2*mag*2^F + steps, divisor 2*steps
   localparam int DIV_BITS     = COORD_BITS + FRAC_BITS + 2;
   localparam int REM_BITS     = COORD_BITS + 2;
   localparam int DIVISOR_BITS = COORD_BITS + 1;
   localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);
   localparam logic [DIV_CNT_BITS-1:0] DIV_CNT_INIT = DIV_CNT_BITS'(DIV_BITS);
   localparam logic [DIV_CNT_BITS-1:0] DIV_CNT_ONE  = DIV_CNT_BITS'(1);

   // command queue between front and back
   localparam int CMD_DEPTH    = 2;
   localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_BITS = $clog2(CMD_DEPTH + 1);
   localparam logic [CMD_PTR_BITS-1:0] CMD_PTR_LAST = CMD_PTR_BITS'(CMD_DEPTH - 1);
   localparam logic [CMD_CNT_BITS-1:0] CMD_CNT_FULL = CMD_CNT_BITS'(CMD_DEPTH);

   // item codes
   localparam logic FUNC_LOAD     = 1'b0;
   localparam logic FUNC_STEP     = 1'b1;
   localparam logic STYLE_DOTTED  = 1'b0;
   localparam logic STYLE_DASHDOT = 1'b1;

   // dash-dot pattern: period ten with gaps at phases five and seven
   localparam int PHASE_BITS = 4;
   localparam logic [PHASE_BITS-1:0] PHASE_LAST  = PHASE_BITS'(9);
   localparam logic [PHASE_BITS-1:0] PHASE_GAP_A = PHASE_BITS'(5);
   localparam logic [PHASE_BITS-1:0] PHASE_GAP_B = PHASE_BITS'(7);

   localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

   // classified item from the front
   typedef struct packed {
      logic                  func;
      logic                  style;
      logic [COORD_BITS-1:0] x_start;
      logic [COORD_BITS-1:0] y_start;
      logic                  neg_x;
      logic                  neg_y;
      logic [COORD_BITS-1:0] mag_x;
      logic [COORD_BITS-1:0] mag_y;
      logic [COORD_BITS-1:0] steps;
   } cmd_type;

   // result beat
   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic                  plot;
      logic                  last;
   } rsp_type;

   // divider request from the back
   typedef struct packed {
      logic                  start;
      logic [COORD_BITS-1:0] mag_x;
      logic [COORD_BITS-1:0] mag_y;
      logic [COORD_BITS-1:0] steps;
   } div_req_type;

   // divider status and quotients
   typedef struct packed {
      logic                 busy;
      logic [QUOT_BITS-1:0] quot_x;
      logic [QUOT_BITS-1:0] quot_y;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/dlr_front.sv =====
// dlr_front: classifies an incoming item into a queue command (deltas, signs, step count)
// depends on dlr_pkg
`default_nettype none

module dlr_front (
   input  wire logic                           req_func,
   input  wire logic [dlr_pkg::COORD_BITS-1:0] req_x_start,
   input  wire logic [dlr_pkg::COORD_BITS-1:0] req_y_start,
   input  wire logic [dlr_pkg::COORD_BITS-1:0] req_x_end,
   input  wire logic [dlr_pkg::COORD_BITS-1:0] req_y_end,
   input  wire logic                           req_style,
   output dlr_pkg::cmd_type                    cmd
);

   logic signed [dlr_pkg::COORD_BITS:0] dx;
   logic signed [dlr_pkg::COORD_BITS:0] dy;
   logic [dlr_pkg::COORD_BITS:0]        abs_x;
   logic [dlr_pkg::COORD_BITS:0]        abs_y;
   logic [dlr_pkg::COORD_BITS-1:0]      mag_x;
   logic [dlr_pkg::COORD_BITS-1:0]      mag_y;

   // signed deltas and magnitudes
   assign dx    = $signed({1'b0, req_x_end}) - $signed({1'b0, req_x_start});
   assign dy    = $signed({1'b0, req_y_end}) - $signed({1'b0, req_y_start});
   assign abs_x = dx[dlr_pkg::COORD_BITS] ? (dlr_pkg::COORD_BITS + 1)'(-dx)
                                          : (dlr_pkg::COORD_BITS + 1)'(dx);
   assign abs_y = dy[dlr_pkg::COORD_BITS] ? (dlr_pkg::COORD_BITS + 1)'(-dy)
                                          : (dlr_pkg::COORD_BITS + 1)'(dy);
   assign mag_x = abs_x[dlr_pkg::COORD_BITS-1:0];
   assign mag_y = abs_y[dlr_pkg::COORD_BITS-1:0];

   // pack the command; step count is the larger magnitude
   always_comb begin
      cmd.func    = req_func;
      cmd.style   = req_style;
      cmd.x_start = req_x_start;
      cmd.y_start = req_y_start;
      cmd.neg_x   = dx[dlr_pkg::COORD_BITS];
      cmd.neg_y   = dy[dlr_pkg::COORD_BITS];
      cmd.mag_x   = mag_x;
      cmd.mag_y   = mag_y;
      cmd.steps   = (mag_x > mag_y) ? mag_x : mag_y;
   end

endmodule

`default_nettype wire

// ===== rtl/dlr_fifo.sv =====
// dlr_fifo: short register queue of classified commands between front and back
// depends on dlr_pkg
`default_nettype none

module dlr_fifo (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire dlr_pkg::cmd_type push_data,
   output logic          full,
   input  wire logic      pop,
   output logic          valid,
   output dlr_pkg::cmd_type pop_data
);

   dlr_pkg::cmd_type                   mem_ff [dlr_pkg::CMD_DEPTH];
   logic [dlr_pkg::CMD_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [dlr_pkg::CMD_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [dlr_pkg::CMD_CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                               do_push;
   logic                               do_pop;

   assign full     = (cnt_ff == dlr_pkg::CMD_CNT_FULL);
   assign valid    = (cnt_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == dlr_pkg::CMD_PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == dlr_pkg::CMD_PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/dlr_div.sv =====
// dlr_div: two-lane restoring divider, one quotient bit per lane per cycle
// depends on dlr_pkg; computes round(mag * 2^F / steps) for x and y together
`default_nettype none

module dlr_div (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire dlr_pkg::div_req_type req,
   output dlr_pkg::div_rsp_type rsp
);

   logic                                 busy_ff, busy_in;
   logic [dlr_pkg::DIV_CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [dlr_pkg::DIV_BITS-1:0]         nx_ff, nx_in;
   logic [dlr_pkg::DIV_BITS-1:0]         ny_ff, ny_in;
   logic [dlr_pkg::REM_BITS-1:0]         rx_ff, rx_in;
   logic [dlr_pkg::REM_BITS-1:0]         ry_ff, ry_in;
   logic [dlr_pkg::DIVISOR_BITS-1:0]     d_ff, d_in;
   logic [dlr_pkg::REM_BITS:0]           lane_x;
   logic [dlr_pkg::REM_BITS:0]           lane_y;

   // one restoring step: returns {remainder, quotient bit}
   function automatic logic [dlr_pkg::REM_BITS:0] lane_step(
      input logic [dlr_pkg::REM_BITS-1:0]     r,
      input logic                             nbit,
      input logic [dlr_pkg::DIVISOR_BITS-1:0] d
   );
      logic [dlr_pkg::REM_BITS-1:0] sh;
      logic [dlr_pkg::REM_BITS-1:0] dd;
      sh = {r[dlr_pkg::REM_BITS-2:0], nbit};
      dd = {1'b0, d};
      if (sh >= dd) begin
         lane_step = {sh - dd, 1'b1};
      end else begin
         lane_step = {sh, 1'b0};
      end
   endfunction

   // dividend 2*mag*2^F + steps
   function automatic logic [dlr_pkg::DIV_BITS-1:0] dividend(
      input logic [dlr_pkg::COORD_BITS-1:0] mag,
      input logic [dlr_pkg::COORD_BITS-1:0] steps
   );
      logic [dlr_pkg::DIV_BITS-1:0] m;
      m = dlr_pkg::DIV_BITS'(mag);
      dividend = (m << (dlr_pkg::FRAC_BITS + 1)) + dlr_pkg::DIV_BITS'(steps);
   endfunction

   assign lane_x = lane_step(rx_ff, nx_ff[dlr_pkg::DIV_BITS-1], d_ff);
   assign lane_y = lane_step(ry_ff, ny_ff[dlr_pkg::DIV_BITS-1], d_ff);

   // load on start, otherwise shift one bit per cycle while busy
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      nx_in   = nx_ff;
      ny_in   = ny_ff;
      rx_in   = rx_ff;
      ry_in   = ry_ff;
      d_in    = d_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = dlr_pkg::DIV_CNT_INIT;
         nx_in   = dividend(req.mag_x, req.steps);
         ny_in   = dividend(req.mag_y, req.steps);
         rx_in   = '0;
         ry_in   = '0;
         d_in    = {req.steps, 1'b0};
      end else if (busy_ff) begin
         nx_in   = {nx_ff[dlr_pkg::DIV_BITS-2:0], lane_x[0]};
         ny_in   = {ny_ff[dlr_pkg::DIV_BITS-2:0], lane_y[0]};
         rx_in   = lane_x[dlr_pkg::REM_BITS:1];
         ry_in   = lane_y[dlr_pkg::REM_BITS:1];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == dlr_pkg::DIV_CNT_ONE) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      nx_ff <= nx_in;
      ny_ff <= ny_in;
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      d_ff  <= d_in;
   end

   // quotients never exceed 2^F, so F+1 low bits hold them
   always_comb begin
      rsp.busy   = busy_ff;
      rsp.quot_x = nx_ff[dlr_pkg::QUOT_BITS-1:0];
      rsp.quot_y = ny_ff[dlr_pkg::QUOT_BITS-1:0];
   end

endmodule

`default_nettype wire

// ===== rtl/dlr_back.sv =====
// dlr_back: executes queued commands: line set-up, per-step accumulate, stipple, result register
// depends on dlr_pkg and drives the dlr_div request
`default_nettype none

module dlr_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire dlr_pkg::cmd_type  cmd,
   output logic                   cmd_pop,
   output dlr_pkg::div_req_type   div_req,
   input  wire dlr_pkg::div_rsp_type div_rsp,
   output logic                   rsp_valid,
   output dlr_pkg::rsp_type       rsp,
   input  wire logic              rsp_pop
);

   logic signed [dlr_pkg::ACC_BITS-1:0]   x_acc_ff, x_acc_in;
   logic signed [dlr_pkg::ACC_BITS-1:0]   y_acc_ff, y_acc_in;
   logic                                  neg_x_ff, neg_x_in;
   logic                                  neg_y_ff, neg_y_in;
   logic [dlr_pkg::STEP_BITS-1:0]         idx_ff, idx_in;
   logic [dlr_pkg::STEP_BITS-1:0]         tot_ff, tot_in;
   logic [dlr_pkg::PHASE_BITS-1:0]        phase_ff, phase_in;
   logic                                  style_ff, style_in;
   logic                                  active_ff, active_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   dlr_pkg::rsp_type                      rsp_ff, rsp_in;

   logic                                  take;
   logic signed [dlr_pkg::INC_BITS-1:0]   x_inc;
   logic signed [dlr_pkg::INC_BITS-1:0]   y_inc;
   logic signed [dlr_pkg::ACC_BITS-1:0]   x_sum;
   logic signed [dlr_pkg::ACC_BITS-1:0]   y_sum;
   logic [dlr_pkg::STEP_BITS-1:0]         idx_next;
   logic [dlr_pkg::PHASE_BITS-1:0]        phase_next;
   logic                                  dotted;
   logic                                  zero_len;

   // accumulator to pixel: optional half added, clamp to the screen
   function automatic logic [dlr_pkg::COORD_BITS-1:0] to_pixel(
      input logic signed [dlr_pkg::ACC_BITS-1:0] acc,
      input logic                                rounded
   );
      logic signed [dlr_pkg::ACC_BITS:0] v;
      logic [dlr_pkg::COORD_BITS:0]      whole;
      v = {acc[dlr_pkg::ACC_BITS-1], acc};
      if (rounded) begin
         v = v + (dlr_pkg::ACC_BITS + 1)'(1 << (dlr_pkg::FRAC_BITS - 1));
      end
      whole = v[dlr_pkg::ACC_BITS-1:dlr_pkg::FRAC_BITS];
      if (v[dlr_pkg::ACC_BITS]) begin
         to_pixel = '0;
      end else if (whole > {1'b0, dlr_pkg::COORD_MAX}) begin
         to_pixel = dlr_pkg::COORD_MAX;
      end else begin
         to_pixel = whole[dlr_pkg::COORD_BITS-1:0];
      end
   endfunction

   // a command proceeds when the divider is free and the result slot frees up
   assign take      = cmd_valid && !div_rsp.busy && (!rsp_valid_ff || rsp_pop);
   assign cmd_pop   = take;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign zero_len  = (cmd.steps == '0);

   // divider start on a load with a real length
   always_comb begin
      div_req.start = take && (cmd.func == dlr_pkg::FUNC_LOAD) && !zero_len;
      div_req.mag_x = cmd.mag_x;
      div_req.mag_y = cmd.mag_y;
      div_req.steps = cmd.steps;
   end

   // signed increments from the divider quotients
   assign x_inc = neg_x_ff ? -$signed({1'b0, div_rsp.quot_x})
                           :  $signed({1'b0, div_rsp.quot_x});
   assign y_inc = neg_y_ff ? -$signed({1'b0, div_rsp.quot_y})
                           :  $signed({1'b0, div_rsp.quot_y});

   // step datapath
   assign x_sum = x_acc_ff + dlr_pkg::ACC_BITS'(x_inc);
   assign y_sum = y_acc_ff + dlr_pkg::ACC_BITS'(y_inc);
   assign idx_next   = idx_ff + 1'b1;
   assign phase_next = (phase_ff == dlr_pkg::PHASE_LAST) ? '0 : phase_ff + 1'b1;
   assign dotted     = (style_ff == dlr_pkg::STYLE_DOTTED);

   // command execution
   always_comb begin
      x_acc_in     = x_acc_ff;
      y_acc_in     = y_acc_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      idx_in       = idx_ff;
      tot_in       = tot_ff;
      phase_in     = phase_ff;
      style_in     = style_ff;
      active_in    = active_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      if (take) begin
         rsp_valid_in = 1'b1;
         if (cmd.func == dlr_pkg::FUNC_LOAD) begin
            // new line: start pixel is always drawn
            x_acc_in  = {1'b0, cmd.x_start, {dlr_pkg::FRAC_BITS{1'b0}}};
            y_acc_in  = {1'b0, cmd.y_start, {dlr_pkg::FRAC_BITS{1'b0}}};
            neg_x_in  = cmd.neg_x;
            neg_y_in  = cmd.neg_y;
            idx_in    = '0;
            tot_in    = {1'b0, cmd.steps};
            phase_in  = '0;
            style_in  = cmd.style;
            active_in = !zero_len;
            rsp_in.pixel_x = cmd.x_start;
            rsp_in.pixel_y = cmd.y_start;
            rsp_in.plot    = 1'b1;
            rsp_in.last    = zero_len;
         end else if (!active_ff) begin
            // step with no line
            rsp_in.pixel_x = '0;
            rsp_in.pixel_y = '0;
            rsp_in.plot    = 1'b0;
            rsp_in.last    = 1'b1;
         end else begin
            x_acc_in  = x_sum;
            y_acc_in  = y_sum;
            idx_in    = idx_next;
            phase_in  = phase_next;
            rsp_in.pixel_x = to_pixel(x_sum, dotted);
            rsp_in.pixel_y = to_pixel(y_sum, dotted);
            if (dotted) begin
               rsp_in.plot = !idx_next[0];
            end else begin
               rsp_in.plot = (phase_next != dlr_pkg::PHASE_GAP_A) &&
                             (phase_next != dlr_pkg::PHASE_GAP_B);
            end
            rsp_in.last = (idx_next >= tot_ff);
            if (idx_next >= tot_ff) begin
               active_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_acc_ff     <= '0;
         y_acc_ff     <= '0;
         neg_x_ff     <= 1'b0;
         neg_y_ff     <= 1'b0;
         idx_ff       <= '0;
         tot_ff       <= '0;
         phase_ff     <= '0;
         style_ff     <= dlr_pkg::STYLE_DOTTED;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         x_acc_ff     <= x_acc_in;
         y_acc_ff     <= y_acc_in;
         neg_x_ff     <= neg_x_in;
         neg_y_ff     <= neg_y_in;
         idx_ff       <= idx_in;
         tot_ff       <= tot_in;
         phase_ff     <= phase_in;
         style_ff     <= style_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

// ===== rtl/dda_styled_line_rasterizer.sv =====
// Styled DDA line rasterizer. A load item (func 0) sets up a line and answers at once with
// its start pixel; each step item (func 1) answers with the next pixel, a plot flag
// (dotted: every second step at rounded coordinates; dash-dot: period ten with gaps
// at phases five and seven, truncated coordinates) and a last flag. Both sides are
// queues: push/full in, empty/pop out, with a two-entry command queue and a one-entry
// result register between. Steps stream at one per cycle while results are popped and
// the divider is idle. A load with distinct end points starts a two-lane serial divider
// to form the x and y increments; the next item waits for it, so a load holds back the
// following step until the divider is done. No clearing pass follows reset.
// Depends on dlr_pkg, dlr_front, dlr_fifo, dlr_div and dlr_back.
`default_nettype none

module dda_styled_line_rasterizer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic                           req_func,
   input  wire logic [dlr_pkg::COORD_BITS-1:0] req_x_start,
   input  wire logic [dlr_pkg::COORD_BITS-1:0] req_y_start,
   input  wire logic [dlr_pkg::COORD_BITS-1:0] req_x_end,
   input  wire logic [dlr_pkg::COORD_BITS-1:0] req_y_end,
   input  wire logic                           req_style,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic [dlr_pkg::COORD_BITS-1:0]      rsp_pixel_x,
   output logic [dlr_pkg::COORD_BITS-1:0]      rsp_pixel_y,
   output logic                                rsp_plot,
   output logic                                rsp_last
);

   dlr_pkg::cmd_type      front_cmd;
   dlr_pkg::cmd_type      queue_cmd;
   logic                  queue_valid;
   logic                  queue_pop;
   dlr_pkg::div_req_type  div_req;
   dlr_pkg::div_rsp_type  div_rsp;
   logic                  out_valid;
   dlr_pkg::rsp_type      out_rsp;

   // classify incoming items
   dlr_front u_front (
      .req_func    (req_func),
      .req_x_start (req_x_start),
      .req_y_start (req_y_start),
      .req_x_end   (req_x_end),
      .req_y_end   (req_y_end),
      .req_style   (req_style),
      .cmd         (front_cmd)
   );

   // command queue
   dlr_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_cmd),
      .full      (req_full),
      .pop       (queue_pop),
      .valid     (queue_valid),
      .pop_data  (queue_cmd)
   );

   // increment divider
   dlr_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // line engine and result register
   dlr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd       (queue_cmd),
      .cmd_pop   (queue_pop),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_valid (out_valid),
      .rsp       (out_rsp),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_empty   = !out_valid;
   assign rsp_pixel_x = out_rsp.pixel_x;
   assign rsp_pixel_y = out_rsp.pixel_y;
   assign rsp_plot    = out_rsp.plot;
   assign rsp_last    = out_rsp.last;

endmodule

`default_nettype wire

// ===== rtl/dlr_checker.sv =====
// dlr_checker: port-level assertions for the styled line rasterizer, bound to the top level
// depends on dlr_pkg
`default_nettype none

module dlr_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_push,
   input wire logic                           req_full,
   input wire logic                           rsp_empty,
   input wire logic                           rsp_pop,
   input wire logic [dlr_pkg::COORD_BITS-1:0] rsp_pixel_x,
   input wire logic [dlr_pkg::COORD_BITS-1:0] rsp_pixel_y,
   input wire logic                           rsp_plot,
   input wire logic                           rsp_last
);

   // reset leaves both queues open and empty
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not clear after reset");

   // the command queue only fills through a push beat
   a_full_by_push: assert property (@(posedge clock) disable iff (reset)
      $rose(req_full) |-> $past(req_push))
      else $error("full rose without a push");

   // a waiting result only leaves through a pop beat
   a_empty_by_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_empty) |-> $past(rsp_pop))
      else $error("result vanished without a pop");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> ($stable(rsp_pixel_x) && $stable(rsp_pixel_y) &&
                                    $stable(rsp_plot) && $stable(rsp_last)))
      else $error("stalled result changed");

endmodule

bind dda_styled_line_rasterizer dlr_checker u_dlr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_push    (req_push),
   .req_full    (req_full),
   .rsp_empty   (rsp_empty),
   .rsp_pop     (rsp_pop),
   .rsp_pixel_x (rsp_pixel_x),
   .rsp_pixel_y (rsp_pixel_y),
   .rsp_plot    (rsp_plot),
   .rsp_last    (rsp_last)
);

`default_nettype wire

// ===== sim/tb.sv =====
// tb: self-checking bench for the styled dda line rasterizer (dda_styled_line_rasterizer)
// depends on rtl/dlr_pkg.sv and the rasterizer rtl; every pixel beat is predicted here
// and checked in order while push gaps and pop stalls shift the timing around

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dlr_pkg::*;

   localparam int COORD_LIMIT    = int'(COORD_MAX);
   localparam int RANDOM_ITEMS   = 1100;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 40;

   // block ports
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_push    = 1'b0;
   logic                  req_full;
   logic                  req_func    = FUNC_STEP;
   logic [COORD_BITS-1:0] req_x_start = '0;
   logic [COORD_BITS-1:0] req_y_start = '0;
   logic [COORD_BITS-1:0] req_x_end   = '0;
   logic [COORD_BITS-1:0] req_y_end   = '0;
   logic                  req_style   = STYLE_DOTTED;
   logic                  rsp_empty;
   logic                  rsp_pop     = 1'b0;
   logic [COORD_BITS-1:0] rsp_pixel_x;
   logic [COORD_BITS-1:0] rsp_pixel_y;
   logic                  rsp_plot;
   logic                  rsp_last;

   // bench bookkeeping
   rsp_type pending_pixels[$];
   int      errors         = 0;
   int      items_in       = 0;
   int      loads          = 0;
   int      pixels_checked = 0;
   int      quiet_cycles   = 0;
   int      burst_left     = 1;
   int      rx_tick        = 0;
   bit      draining       = 1'b0;

   // predicted rasterizer state
   logic signed [ACC_BITS-1:0] acc_x, acc_y;
   logic signed [INC_BITS-1:0] inc_x, inc_y;
   logic [STEP_BITS-1:0]       steps_done, steps_in_line;
   logic [PHASE_BITS-1:0]      dash_phase;
   logic                       line_style;
   bit                         line_live;

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   dda_styled_line_rasterizer uut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_func    (req_func),
      .req_x_start (req_x_start),
      .req_y_start (req_y_start),
      .req_x_end   (req_x_end),
      .req_y_end   (req_y_end),
      .req_style   (req_style),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_pixel_x (rsp_pixel_x),
      .rsp_pixel_y (rsp_pixel_y),
      .rsp_plot    (rsp_plot),
      .rsp_last    (rsp_last)
   );

   // per-step slope: |d| * 2^F / span, rounded half away from zero, then signed
   function automatic logic signed [INC_BITS-1:0] fixed_slope(input int d, input int span);
      longint mag;
      longint q;
      mag = (d < 0) ? -d : d;
      q = (2 * (mag << FRAC_BITS) + span) / (2 * span);
      return (d < 0) ? INC_BITS'(-q) : INC_BITS'(q);
   endfunction

   // accumulator to screen coordinate, clamped to the coordinate range
   function automatic logic [COORD_BITS-1:0] snap(input logic signed [ACC_BITS-1:0] acc,
                                                   input bit rounded);
      longint v;
      v = acc;
      if (rounded) v += longint'(1) << (FRAC_BITS - 1);
      if (v < 0) return '0;
      v = v >>> FRAC_BITS;
      if (v > longint'(COORD_MAX)) return COORD_MAX;
      return COORD_BITS'(v);
   endfunction

   // advance the predicted state by one input beat and return the pixel it yields
   function automatic rsp_type raster_next(input logic func,
                                           input logic [COORD_BITS-1:0] xs, ys, xe, ye,
                                           input logic style);
      rsp_type beat;
      int      dx, dy, span;
      bit      dotted;
      if (func == FUNC_LOAD) begin
         dx = int'(xe) - int'(xs);
         dy = int'(ye) - int'(ys);
         span = (dx < 0) ? -dx : dx;
         if (((dy < 0) ? -dy : dy) > span) span = (dy < 0) ? -dy : dy;
         line_style    = style;
         acc_x         = $signed({1'b0, xs, {FRAC_BITS{1'b0}}});
         acc_y         = $signed({1'b0, ys, {FRAC_BITS{1'b0}}});
         steps_done    = '0;
         dash_phase    = '0;
         steps_in_line = STEP_BITS'(span);
         if (span == 0) begin
            inc_x     = '0;
            inc_y     = '0;
            line_live = 1'b0;
         end else begin
            inc_x     = fixed_slope(dx, span);
            inc_y     = fixed_slope(dy, span);
            line_live = 1'b1;
         end
         beat = '{pixel_x: xs, pixel_y: ys, plot: 1'b1, last: !line_live};
      end else if (!line_live) begin
         beat = '{pixel_x: '0, pixel_y: '0, plot: 1'b0, last: 1'b1};
      end else begin
         steps_done = steps_done + 1'b1;
         dash_phase = (dash_phase == PHASE_LAST) ? '0 : dash_phase + 1'b1;
         acc_x      = acc_x + inc_x;
         acc_y      = acc_y + inc_y;
         dotted     = (line_style == STYLE_DOTTED);
         beat.pixel_x = snap(acc_x, dotted);
         beat.pixel_y = snap(acc_y, dotted);
         beat.plot    = dotted ? !steps_done[0]
                               : (dash_phase != PHASE_GAP_A && dash_phase != PHASE_GAP_B);
         beat.last    = (steps_done >= steps_in_line);
         if (beat.last) line_live = 1'b0;
      end
      return beat;
   endfunction

   // send one beat, record its prediction, then idle between bursts
   task automatic push_item(input logic func, input logic [COORD_BITS-1:0] xs, ys, xe, ye,
                            input logic style);
      int gap;
      req_func    = func;
      req_x_start = xs;
      req_y_start = ys;
      req_x_end   = xe;
      req_y_end   = ye;
      req_style   = style;
      req_push    = 1'b1;
      do @(posedge clock); while (req_full);
      pending_pixels.push_back(raster_next(func, xs, ys, xe, ye, style));
      items_in++;
      if (func == FUNC_LOAD) loads++;
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
         if (gap > 0) begin
            req_push    = 1'b0;
            req_func    = 1'($urandom);
            req_x_start = COORD_BITS'($urandom);
            req_y_start = COORD_BITS'($urandom);
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // step beats carry junk in the coordinate fields, which the block ignores
   task automatic step_n(input int count);
      repeat (count)
         push_item(FUNC_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                   COORD_BITS'($urandom), COORD_BITS'($urandom), 1'($urandom));
   endtask

   // random end point near a start point, kept on screen
   function automatic int near_end(input int from, input int reach);
      int v;
      v = from + int'($urandom_range(0, 2 * reach)) - reach;
      if (v < 0) v = 0;
      if (v > COORD_LIMIT) v = COORD_LIMIT;
      return v;
   endfunction

   // steps with no line loaded since reset
   task automatic test_idle_steps();
      step_n(2);
   endtask

   // identical end points give only the start pixel; a step after it is idle
   task automatic test_degenerate_load();
      push_item(FUNC_LOAD, COORD_MAX, '0, COORD_MAX, '0, STYLE_DASHDOT);
      step_n(1);
   endtask

   // full-screen diagonals, each abandoned by the next load, then reversed direction
   task automatic test_abandon_and_reverse();
      push_item(FUNC_LOAD, '0, '0, COORD_MAX, COORD_MAX, STYLE_DASHDOT);
      step_n(2);
      push_item(FUNC_LOAD, COORD_MAX, COORD_MAX, '0, '0, STYLE_DOTTED);
      step_n(2);
   endtask

   // dash-dot line long enough to pass both gap phases, run to its end and beyond
   task automatic test_dashdot_phases();
      push_item(FUNC_LOAD, 10'd10, 10'd20, 10'd0, 10'd8, STYLE_DASHDOT);
      step_n(13);
   endtask

   // mostly whole lines of random shape, some cut short, plus raw noise beats
   task automatic test_random_lines();
      int first, pick, reach, xs, ys, xe, ye, span, nsteps;
      first = items_in;
      while (items_in - first < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         xs   = $urandom_range(0, COORD_LIMIT);
         ys   = $urandom_range(0, COORD_LIMIT);
         if (pick < 8) begin
            push_item(1'($urandom), COORD_BITS'(xs), COORD_BITS'(ys), COORD_BITS'($urandom),
                      COORD_BITS'($urandom), 1'($urandom));
         end else begin
            reach = (pick < 12) ? 0 : (pick < 80) ? 15 : (pick < 97) ? 80 : COORD_LIMIT;
            xe    = near_end(xs, reach);
            ye    = near_end(ys, reach);
            span  = (xe > xs) ? xe - xs : xs - xe;
            if (((ye > ys) ? ye - ys : ys - ye) > span) span = (ye > ys) ? ye - ys : ys - ye;
            nsteps = ($urandom_range(0, 6) == 0) ? $urandom_range(0, span)
                                                 : span + $urandom_range(0, 2);
            // keep the total close to the item budget
            if (nsteps > RANDOM_ITEMS - (items_in - first) - 1)
               nsteps = RANDOM_ITEMS - (items_in - first) - 1;
            push_item(FUNC_LOAD, COORD_BITS'(xs), COORD_BITS'(ys), COORD_BITS'(xe),
                      COORD_BITS'(ye), 1'($urandom));
            step_n(nsteps);
         end
      end
   endtask

   // receiver stall pattern, with the style chosen by rx_tick[8:6]
   always @(negedge clock) begin
      rx_tick <= rx_tick + 1;
      if (reset)
         rsp_pop <= 1'b0;
      else if (draining)
         rsp_pop <= 1'b1;
      else begin
         case (rx_tick[8:6])
            3'd2:    rsp_pop <= 1'($urandom);
            3'd3:    rsp_pop <= (rx_tick[1:0] == 2'd0);
            3'd4:    rsp_pop <= (rx_tick[4:0] >= 5'd24);
            3'd5:    rsp_pop <= ($urandom_range(0, 7) != 0);
            3'd6:    rsp_pop <= (rx_tick[2:0] != 3'd3);
            3'd7:    rsp_pop <= ($urandom_range(0, 3) == 0);
            default: rsp_pop <= 1'b1;
         endcase
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   // compare each popped result beat against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_pixels.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat, expected none %s",
                     $time, "actual");
            $display("   x=%0d y=%0d plot=%0d last=%0d",
                     rsp_pixel_x, rsp_pixel_y, rsp_plot, rsp_last);
         end else begin
            want = pending_pixels.pop_front();
            pixels_checked++;
            check_field("pixel_x", want.pixel_x, rsp_pixel_x);
            check_field("pixel_y", want.pixel_y, rsp_pixel_y);
            check_field("plot", want.plot, rsp_plot);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   // watchdog: too long with no beat moving on either side ends the run
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         quiet_cycles <= 0;
      else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d results outstanding",
                  $time, pending_pixels.size());
         $display("[FAIL] regression broken");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      line_live     = 1'b0;
      line_style    = STYLE_DOTTED;
      acc_x         = '0;
      acc_y         = '0;
      inc_x         = '0;
      inc_y         = '0;
      steps_done    = '0;
      steps_in_line = '0;
      dash_phase    = '0;
      reset         = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_idle_steps();
      test_degenerate_load();
      test_abandon_and_reverse();
      test_dashdot_phases();
      test_random_lines();

      // drain outstanding results, then watch for strays
      req_push = 1'b0;
      draining = 1'b1;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      errors += pending_pixels.size();

      $display("run covered %0d input beats (%0d line loads) and %0d checked pixel beats,",
               items_in, loads, pixels_checked);
      $display("with bursty pushes, patterned pop stalls and both line styles");
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
